// ----- hdl/frc_pkg.sv -----
// Shared constants for the channel level filter and ranker.
`default_nettype none
package frc_pkg;
    localparam int SAMPLE_IN_W       = 12;
    localparam int CHANNEL_W         = 3;
    localparam int WEIGHT_W          = 9;
    localparam int FRAC_W            = 8;
    localparam int LEVEL_OUT_W       = 20;
    localparam int IN_TDATA_W        = 16;
    localparam int IN_TUSER_W        = CHANNEL_W;
    localparam int OUT_TDATA_W       = 72;
    localparam int CHANNEL_COUNT_DEF = 5;
    localparam int SAMPLE_WIDTH_DEF  = 12;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 9'd256;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd64;
endpackage
`default_nettype wire

// ----- hdl/frc_filter.sv -----
// First-order low-pass update of one channel level in fixed point.
`default_nettype none
module frc_filter #(
    parameter int SAMPLE_WIDTH = frc_pkg::SAMPLE_WIDTH_DEF,
    parameter int LVL_W        = SAMPLE_WIDTH + frc_pkg::FRAC_W
) (
    input  wire logic [LVL_W-1:0]                i_old,
    input  wire logic [frc_pkg::SAMPLE_IN_W-1:0] i_sample,
    input  wire logic [frc_pkg::WEIGHT_W-1:0]    i_weight,
    output logic      [LVL_W-1:0]                o_new,
    output logic      [LVL_W-1:0]                o_target
);
    import frc_pkg::*;

    localparam int EXT_W  = (SAMPLE_IN_W > SAMPLE_WIDTH) ? SAMPLE_IN_W : SAMPLE_WIDTH;
    localparam int PROD_W = LVL_W + WEIGHT_W + 2;

    logic [EXT_W-1:0]          w_sample_ext;
    logic [WEIGHT_W-1:0]       w_weight;
    logic signed [LVL_W:0]     w_diff;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [PROD_W-1:0]  w_step;

    assign w_sample_ext = EXT_W'(i_sample);
    assign o_target     = {w_sample_ext[SAMPLE_WIDTH-1:0], {FRAC_W{1'b0}}};
    assign w_weight     = (i_weight > WEIGHT_ONE) ? WEIGHT_ONE : i_weight;

    // old*(1-w) + target*w equals old + w*(target-old); the floor shift keeps rounding.
    assign w_diff = $signed({1'b0, o_target}) - $signed({1'b0, i_old});
    assign w_prod = PROD_W'(w_diff) * PROD_W'($signed({1'b0, w_weight}));
    assign w_step = (w_prod + PROD_W'(signed'(1 << (FRAC_W - 1)))) >>> FRAC_W;
    assign o_new  = i_old + w_step[LVL_W-1:0];
endmodule
`default_nettype wire

// ----- hdl/filter_and_rank_channels.sv -----
// Channel level filter and ranker: smooths each channel and ranks levels per scan.
// A result is registered after the transaction of the last channel.
// One input transaction per cycle unless the last of a scan waits on the output;
// the filter multiply and the ranking compare sit in one stage between the input
// register and the result register. Reset clears the level store, the ranking
// state and both valid flags; it sets the smoothing weight to 64 and is then ready.
`default_nettype none
module filter_and_rank_channels #(
    parameter int CHANNEL_COUNT = frc_pkg::CHANNEL_COUNT_DEF,
    parameter int SAMPLE_WIDTH  = frc_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [frc_pkg::WEIGHT_W-1:0]     i_cfg_data,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // sample [11:0], zero [15:12]
    input  wire logic [frc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  wire logic                             s_axis_tlast,
    // channel [2:0]
    input  wire logic [frc_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // top_channel [2:0], runner_up_channel [5:3], top_level [25:6],
    // runner_up_level [45:26], bottom_level [65:46], zero [71:66]
    output logic      [frc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import frc_pkg::*;

    localparam int LVL_W = SAMPLE_WIDTH + FRAC_W;
    localparam int IDX_W = $clog2(CHANNEL_COUNT);
    localparam int OUT_W = (LVL_W > LEVEL_OUT_W) ? LVL_W : LEVEL_OUT_W;

    logic [WEIGHT_W-1:0]    r_weight;
    logic                   r_in_valid;
    logic [SAMPLE_IN_W-1:0] r_in_sample;
    logic [CHANNEL_W-1:0]   r_in_channel;
    logic                   r_in_last;
    logic [LVL_W-1:0]       r_levels [CHANNEL_COUNT];
    logic [LVL_W-1:0]       r_best_lvl, r_second_lvl, r_least_lvl;
    logic [CHANNEL_W-1:0]   r_best_idx, r_second_idx;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [LVL_W-1:0]       n_best_lvl, n_second_lvl, n_least_lvl;
    logic [CHANNEL_W-1:0]   n_best_idx, n_second_idx;
    logic [OUT_TDATA_W-1:0] n_out_data;

    logic                   w_in_range;
    logic [IDX_W-1:0]       w_idx;
    logic [LVL_W-1:0]       w_old;
    logic [LVL_W-1:0]       w_new;
    logic [LVL_W-1:0]       w_target;
    logic                   w_out_free;
    logic                   w_advance;
    logic                   w_emit;
    logic [OUT_W-1:0]       w_best_ext, w_second_ext, w_least_ext;

    assign o_cfg_ready = 1'b1;

    assign w_in_range = {1'b0, r_in_channel} < (CHANNEL_W + 1)'(CHANNEL_COUNT);
    assign w_idx      = r_in_channel[IDX_W-1:0];
    assign w_old      = w_in_range ? r_levels[w_idx] : '0;

    frc_filter #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .LVL_W        (LVL_W)
    ) u_filter (
        .i_old    (w_old),
        .i_sample (r_in_sample),
        .i_weight (r_weight),
        .o_new    (w_new),
        .o_target (w_target)
    );

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_advance     = r_in_valid && (!(w_in_range && r_in_last) || w_out_free);
    assign w_emit        = w_advance && w_in_range && r_in_last;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        n_best_lvl   = r_best_lvl;
        n_second_lvl = r_second_lvl;
        n_least_lvl  = r_least_lvl;
        n_best_idx   = r_best_idx;
        n_second_idx = r_second_idx;
        if (r_in_channel == '0) begin
            n_best_lvl   = w_new;
            n_second_lvl = w_new;
            n_least_lvl  = w_new;
            n_best_idx   = '0;
            n_second_idx = '0;
        end else begin
            if (w_new > r_best_lvl) begin
                n_second_lvl = r_best_lvl;
                n_second_idx = r_best_idx;
                n_best_lvl   = w_new;
                n_best_idx   = r_in_channel;
            end else if ((r_in_channel == CHANNEL_W'(1)) || (w_new > r_second_lvl)) begin
                // Channel one always takes the second place when it does not lead.
                n_second_lvl = w_new;
                n_second_idx = r_in_channel;
            end
            if (w_new < r_least_lvl) begin
                n_least_lvl = w_new;
            end
        end
    end

    assign w_best_ext   = OUT_W'(n_best_lvl);
    assign w_second_ext = OUT_W'(n_second_lvl);
    assign w_least_ext  = OUT_W'(n_least_lvl);

    always_comb begin
        n_out_data         = '0;
        n_out_data[2:0]    = n_best_idx;
        n_out_data[5:3]    = n_second_idx;
        n_out_data[25:6]   = w_best_ext[LEVEL_OUT_W-1:0];
        n_out_data[45:26]  = w_second_ext[LEVEL_OUT_W-1:0];
        n_out_data[65:46]  = w_least_ext[LEVEL_OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WEIGHT_RESET;
        end else if (i_cfg_valid) begin
            r_weight <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_sample  <= s_axis_tdata[SAMPLE_IN_W-1:0];
            r_in_channel <= s_axis_tuser;
            r_in_last    <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                r_levels[i] <= '0;
            end
            r_best_lvl   <= '0;
            r_second_lvl <= '0;
            r_least_lvl  <= '0;
            r_best_idx   <= '0;
            r_second_idx <= '0;
        end else if (w_advance && w_in_range) begin
            r_levels[w_idx] <= w_new;
            r_best_lvl      <= n_best_lvl;
            r_second_lvl    <= n_second_lvl;
            r_least_lvl     <= n_least_lvl;
            r_best_idx      <= n_best_idx;
            r_second_idx    <= n_second_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data <= n_out_data;
        end
    end

`ifndef SYNTHESIS
    a_rank_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_best_lvl >= r_second_lvl) && (r_least_lvl <= r_best_lvl))
        else $error("Ranking state out of order.");

    a_filter_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_in_range) |->
            (((w_new >= w_old) && (w_new <= w_target)) ||
             ((w_new <= w_old) && (w_new >= w_target))))
        else $error("Filtered level left the span between old level and sample.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> r_in_valid)
        else $error("Stalled input transaction was dropped.");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> r_out_valid)
        else $error("Last channel of a scan gave no result.");
`endif
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the channel level filter and ranker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import frc_pkg::*;

    localparam int CHANNELS = CHANNEL_COUNT_DEF;

    typedef struct packed {
        logic [OUT_TDATA_W-66-1:0] pad;
        logic [LEVEL_OUT_W-1:0]    bottom_level;
        logic [LEVEL_OUT_W-1:0]    runner_up_level;
        logic [LEVEL_OUT_W-1:0]    top_level;
        logic [CHANNEL_W-1:0]      runner_up_channel;
        logic [CHANNEL_W-1:0]      top_channel;
    } ranking_t;

    class scan_ranker;
        logic [WEIGHT_W-1:0]    weight;
        logic [LEVEL_OUT_W-1:0] channel_level [CHANNELS];
        logic [LEVEL_OUT_W-1:0] best_lvl;
        logic [LEVEL_OUT_W-1:0] second_lvl;
        logic [LEVEL_OUT_W-1:0] least_lvl;
        logic [CHANNEL_W-1:0]   best_ch;
        logic [CHANNEL_W-1:0]   second_ch;
        ranking_t               expected_rankings [$];
        int                     error_count;
        int                     sample_count;
        int                     ranking_count;

        function new();
            weight = WEIGHT_RESET;
            foreach (channel_level[i]) channel_level[i] = '0;
            best_lvl = '0;
            second_lvl = '0;
            least_lvl = '0;
            best_ch = '0;
            second_ch = '0;
            error_count = 0;
            sample_count = 0;
            ranking_count = 0;
        endfunction

        function void set_weight(logic [WEIGHT_W-1:0] w);
            weight = w;
        endfunction

        function void note_sample(logic [SAMPLE_IN_W-1:0] smp, logic [CHANNEL_W-1:0] ch,
                                  logic is_last);
            longint                 w;
            longint                 acc;
            logic [LEVEL_OUT_W-1:0] lvl;
            ranking_t               r;
            if (ch >= CHANNELS) return;
            sample_count++;
            w = (weight > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(weight);
            acc = longint'(channel_level[ch]) * (256 - w)
                + (longint'(smp) << FRAC_W) * w + 128;
            lvl = LEVEL_OUT_W'(acc >> FRAC_W);
            channel_level[ch] = lvl;
            if (ch == 0) begin
                best_lvl = lvl;
                second_lvl = lvl;
                least_lvl = lvl;
                best_ch = '0;
                second_ch = '0;
            end else begin
                if (ch == 1) begin
                    if (lvl > best_lvl) begin
                        second_lvl = best_lvl;
                        second_ch = best_ch;
                        best_lvl = lvl;
                        best_ch = ch;
                    end else begin
                        second_lvl = lvl;
                        second_ch = ch;
                    end
                end else if (lvl > best_lvl) begin
                    second_lvl = best_lvl;
                    second_ch = best_ch;
                    best_lvl = lvl;
                    best_ch = ch;
                end else if (lvl > second_lvl) begin
                    second_lvl = lvl;
                    second_ch = ch;
                end
                if (lvl < least_lvl) least_lvl = lvl;
            end
            if (is_last) begin
                r = '0;
                r.top_channel = best_ch;
                r.runner_up_channel = second_ch;
                r.top_level = best_lvl;
                r.runner_up_level = second_lvl;
                r.bottom_level = least_lvl;
                expected_rankings.push_back(r);
            end
        endfunction

        function void compare_field(string name, int exp_val, int act_val);
            if (exp_val != act_val) begin
                $error("%s: expected %0d, got %0d", name, exp_val, act_val);
                error_count++;
            end
        endfunction

        function void check_ranking(logic [OUT_TDATA_W-1:0] data);
            ranking_t act;
            ranking_t exp_r;
            act = ranking_t'(data);
            ranking_count++;
            if (expected_rankings.size() == 0) begin
                $error("ranking result with none expected: %h", data);
                error_count++;
                return;
            end
            exp_r = expected_rankings.pop_front();
            compare_field("top_channel", exp_r.top_channel, act.top_channel);
            compare_field("runner_up_channel", exp_r.runner_up_channel, act.runner_up_channel);
            compare_field("top_level", exp_r.top_level, act.top_level);
            compare_field("runner_up_level", exp_r.runner_up_level, act.runner_up_level);
            compare_field("bottom_level", exp_r.bottom_level, act.bottom_level);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [WEIGHT_W-1:0]    i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    scan_ranker ranker = new();
    bit         gaps_on = 1'b1;
    bit         hold_request = 1'b0;
    int         weight_settings = 0;

    filter_and_rank_channels DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (120) @(posedge i_clk);
                hold_request = 1'b0;
            end
            m_axis_tready <= !(gaps_on && $urandom_range(99) < 26);
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) ranker.check_ranking(m_axis_tdata);
    end

    task automatic send_item(input logic [SAMPLE_IN_W-1:0] smp, input logic [CHANNEL_W-1:0] ch,
                             input logic is_last);
        while (gaps_on && $urandom_range(99) < 26) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_TDATA_W-SAMPLE_IN_W){1'b0}}, smp};
        s_axis_tuser <= ch;
        s_axis_tlast <= is_last;
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        ranker.note_sample(smp, ch, is_last);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (ranker.expected_rankings.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_weight(input logic [WEIGHT_W-1:0] w);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= w;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        ranker.set_weight(w);
        weight_settings++;
    endtask

    function automatic logic [SAMPLE_IN_W-1:0] pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        if (r < 35) return SAMPLE_IN_W'(2048);
        return SAMPLE_IN_W'($urandom);
    endfunction

    task automatic run_phase(input int quota);
        int sent;
        int len;
        int r;
        logic [CHANNEL_W-1:0] ch;
        sent = 0;
        while (sent < quota) begin
            r = $urandom_range(99);
            if (r < 80) begin
                len = $urandom_range(1, CHANNELS);
                for (int c = 0; c < len; c++) send_item(pick_sample(), CHANNEL_W'(c), c == len - 1);
                sent += len;
            end else if (r < 92) begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++) begin
                    ch = CHANNEL_W'($urandom_range(0, 7));
                    send_item(pick_sample(), ch, $urandom_range(99) < 30);
                    if (ch < CHANNELS) sent++;
                end
            end else begin
                send_item(pick_sample(), CHANNEL_W'($urandom_range(CHANNELS, 7)),
                          1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        logic [WEIGHT_W-1:0] phase_weight [8];
        phase_weight[0] = WEIGHT_ONE;
        phase_weight[1] = 9'd1;
        phase_weight[2] = 9'd255;
        phase_weight[3] = WEIGHT_W'($urandom_range(2, 254));
        phase_weight[4] = 9'd0;
        phase_weight[5] = 9'd511;
        phase_weight[6] = WEIGHT_W'($urandom_range(257, 510));
        phase_weight[7] = WEIGHT_W'($urandom_range(0, 511));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Ranking state is still zero, so a scan that skips channel 0 ranks against it.
        send_item('1, 3'd2, 1'b1);
        send_item('1, 3'd0, 1'b1);
        send_item('1, 3'd5, 1'b1);
        send_item('0, 3'd7, 1'b1);
        send_item('0, 3'd0, 1'b0);
        send_item('1, 3'd1, 1'b0);
        send_item('1, 3'd2, 1'b0);
        send_item('0, 3'd3, 1'b0);
        send_item('1, 3'd4, 1'b1);

        write_weight(WEIGHT_ONE);
        for (int c = 0; c < CHANNELS; c++)
            send_item(SAMPLE_IN_W'(1000), CHANNEL_W'(c), c == CHANNELS - 1);
        send_item('1, 3'd0, 1'b0);
        send_item(SAMPLE_IN_W'(10), 3'd1, 1'b0);
        send_item(SAMPLE_IN_W'(2000), 3'd2, 1'b0);
        send_item(SAMPLE_IN_W'(3000), 3'd3, 1'b0);
        send_item(SAMPLE_IN_W'(5), 3'd4, 1'b1);
        send_item(SAMPLE_IN_W'(7), 3'd3, 1'b0);
        send_item(SAMPLE_IN_W'(100), 3'd1, 1'b1);

        write_weight(9'd0);
        send_item('1, 3'd0, 1'b0);
        send_item('0, 3'd1, 1'b1);

        write_weight(9'd511);
        send_item(SAMPLE_IN_W'(123), 3'd0, 1'b0);
        send_item('1, 3'd4, 1'b1);

        for (int p = 0; p < 8; p++) begin
            write_weight(phase_weight[p]);
            gaps_on = !(p == 3 || p == 5);
            if (p == 3) hold_request = 1'b1;
            run_phase(165);
        end
        gaps_on = 1'b1;

        drain();
        $display("Run covered %0d channel samples under %0d weight settings.",
                 ranker.sample_count, weight_settings);
        $display("Checked %0d ranking results against the predictor.", ranker.ranking_count);
        if (ranker.error_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule

// ----- files.f -----
hdl/frc_pkg.sv
hdl/frc_filter.sv
hdl/filter_and_rank_channels.sv
tb/tb.sv
